### sv/srt_pkg.sv
// Shared types and constants for the search result table.
`timescale 1ns / 1ps
package srt_pkg;

  localparam int KEY_W     = 64;
  localparam int DEPTH_W   = 8;
  localparam int SCORE_W   = 16;
  localparam int FLAG_W    = 2;
  localparam int KIND_W    = 2;
  localparam int LIMIT_W   = 7;
  localparam int COUNTER_W = 32;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 64;

  localparam logic [KIND_W-1:0] KIND_PROBE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // One stored table entry.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0] depth;
    logic [FLAG_W-1:0]  flag;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_search;
    logic done;
    logic out_free;
  } ctrl_status_t;

endpackage

### sv/srt_controller.sv
// Controller state machine that sequences load, key scan and finish.
`timescale 1ns / 1ps
module srt_controller
  import srt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output ctrl_cmd_t    cmd,
  input  ctrl_status_t st
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = st.item_search ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (st.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/srt_datapath.sv
// Datapath: entry memory, key scan, update rules, counters and result register.
`timescale 1ns / 1ps
module srt_datapath
  import srt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic                  cfg_valid,
  input  logic [LIMIT_W-1:0]    cfg_data,
  input  ctrl_cmd_t             cmd,
  output ctrl_status_t          st,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

  entry_t mem [CAPACITY];

  logic [KIND_W-1:0]    it_kind;
  logic [KEY_W-1:0]     it_hash;
  logic [DEPTH_W-1:0]   it_depth;
  logic [SCORE_W-1:0]   it_score;
  logic [FLAG_W-1:0]    it_flag;
  logic [LIMIT_W-1:0]   max_entries;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [COUNTER_W-1:0] hit_counter;
  logic [COUNTER_W-1:0] hit_counter_next;
  logic [CW-1:0]        rd_idx;
  logic [AW-1:0]        cmp_idx;
  logic                 rd_vld;
  entry_t               rd_data;

  logic          key_match;
  logic          issue;
  logic          full;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          res_hit;
  logic          res_written;
  logic          res_dropped;

  assign key_match = rd_vld && (rd_data.key == it_hash);
  assign issue     = cmd.scan && !key_match && (rd_idx != count);

  assign st.item_search = (in_kind == KIND_PROBE) || (in_kind == KIND_STORE);
  assign st.done        = key_match || (rd_idx == count);
  assign st.out_free    = !out_valid || out_ready;

  // Full when the count reaches the register limit or the capacity.
  assign full = (LW'(count) >= LW'(max_entries)) || (count >= CAP_COUNT);

  always_comb begin
    res_hit          = 1'b0;
    res_written      = 1'b0;
    res_dropped      = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = cmp_idx;
    count_next       = count;
    hit_counter_next = hit_counter;
    unique case (it_kind)
      KIND_PROBE: begin
        if (key_match && (rd_data.depth >= it_depth)) begin
          res_hit = 1'b1;
          if (hit_counter != '1) begin
            hit_counter_next = hit_counter + 1'b1;
          end
        end
      end
      KIND_STORE: begin
        if (key_match) begin
          if (!(full && (rd_data.depth > it_depth))) begin
            wr_en       = 1'b1;
            res_written = 1'b1;
          end
        end else if (full) begin
          res_dropped = 1'b1;
        end else begin
          wr_en       = 1'b1;
          wr_addr     = count[AW-1:0];
          count_next  = count + 1'b1;
          res_written = 1'b1;
        end
      end
      KIND_CLEAR: begin
        count_next       = '0;
        hit_counter_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Item capture and configuration.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_kind  <= in_kind;
      it_hash  <= in_data[63:0];
      it_depth <= in_data[71:64];
      it_score <= in_data[87:72];
      it_flag  <= in_data[89:88];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= LIMIT_RESET;
    end else if (cfg_valid) begin
      max_entries <= cfg_data;
    end
  end

  // Scan: one memory read issued per cycle, the previous read compared.
  // A matching read stays valid so the finishing step still sees the match.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.load) begin
      rd_idx <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.scan) begin
      rd_vld <= issue || key_match;
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[rd_idx[AW-1:0]];
      cmp_idx <= rd_idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && wr_en) begin
      mem[wr_addr] <= '{key: it_hash, score: it_score, depth: it_depth, flag: it_flag};
    end
  end

  // Table state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      hit_counter <= '0;
    end else if (cmd.finish) begin
      count       <= count_next;
      hit_counter <= hit_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= {3'b000, hit_counter_next, res_dropped, res_written,
                   res_hit ? rd_data.flag  : {FLAG_W{1'b0}},
                   res_hit ? rd_data.depth : {DEPTH_W{1'b0}},
                   res_hit ? rd_data.score : {SCORE_W{1'b0}},
                   res_hit};
    end
  end

endmodule

### sv/search_result_table_top.sv
// Top level of the search result table: controller plus datapath.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                   Payload
//  s_axis    in         s_axis_tvalid/tready        tdata: item fields, tuser: kind
//  m_axis    out        m_axis_tvalid/tready        tdata: result fields
//  cfg       in         cfg_valid/cfg_ready         cfg_data: max_entries
//
//  A probe or store that finds no key scans every stored entry before the
//  output register is loaded; a key found at entry k ends the scan early.
//  The key scan reads the single entry memory port once per cycle and
//  compares the previous read, so the scan length grows with the stored
//  count. A clear or an unused kind skips the scan. One item is in work at
//  a time; a new item is accepted while the previous result waits in the
//  output register. Reset is synchronous and active high; the table is
//  empty after reset with no clearing pass. A stalled output holds the
//  finishing step until it drains.
//
module search_result_table_top
  import srt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0 up: hash[63:0], depth[71:64], score[87:72],
  // bound_flag[89:88], zero fill[95:90].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0 up: kind[1:0].
  input  logic [KIND_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0 up: hit[0], entry_score[16:1], entry_depth[24:17],
  // entry_flag[26:25], written[27], dropped_full[28], hit_total[60:29],
  // zero fill[63:61].
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LIMIT_W-1:0]    cfg_data
);

  ctrl_cmd_t    cmd;
  ctrl_status_t st;

  // The limit register can always take a write.
  assign cfg_ready = 1'b1;

  srt_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .st       (st)
  );

  srt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .in_kind   (s_axis_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

### sv/srt_checker.sv
// Port-level checks for the search result table, bound to the top level.
`timescale 1ns / 1ps
module srt_checker
  import srt_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // Only one item is in work: acceptance closes the input until it finishes.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // Entry fields are zero unless the probe hit.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[26:1] == 26'd0))
    else $error("entry fields nonzero without a hit");

  // A result is never both a hit and a store outcome, nor written and dropped.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[28:27]) &&
                      !(m_axis_tdata[0] && (m_axis_tdata[28:27] != 2'b00)))
    else $error("conflicting result flags");

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind search_result_table_top srt_checker u_srt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
